FILE: hdl/life_grid_generation_macros.svh
// ----------------------------------------------------------------------------
// life_grid_generation_macros
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_MACROS_SVH
`define LIFE_GRID_GENERATION_MACROS_SVH

// same-cycle implication, off during reset
`define LGG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define LGG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/lgg_pkg.sv
// ----------------------------------------------------------------------------
// lgg_pkg
// types, constants and the cell rule for the life grid generation block
// ----------------------------------------------------------------------------
`default_nettype none

package lgg_pkg;

    localparam int ROWS = 16;
    localparam int COLS = 16;

    localparam int ROW_AW = $clog2(ROWS);

    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);
    localparam logic [ROW_AW:0]   ROWS_EXT = (ROW_AW + 1)'(ROWS);

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [3:0] row;
        logic [3:0] col;
        logic       alive;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  row_index;
        logic [15:0] row_cells;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic rd_cell;
        logic write_cell;
        logic rd_first;
        logic load_window;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_advance;
        logic cell_in_range;
        logic out_free;
        logic last_row;
    } ctrl_sts_t;

    // B3/S23 on one row, given the rows above and below
    function automatic logic [COLS-1:0] life_row(
        input logic [COLS-1:0] above,
        input logic [COLS-1:0] mid,
        input logic [COLS-1:0] below
    );
        logic [COLS-1:0] res;
        logic [3:0]      n;
        res = '0;
        for (int j = 0; j < COLS; j++)
        begin
            n = 4'(above[j]) + 4'(below[j]);
            if (j > 0)
            begin
                n = n + 4'(above[j-1]) + 4'(mid[j-1]) + 4'(below[j-1]);
            end
            if (j < COLS - 1)
            begin
                n = n + 4'(above[j+1]) + 4'(mid[j+1]) + 4'(below[j+1]);
            end
            res[j] = (n == 4'd3) || (mid[j] && (n == 4'd2));
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/lgg_ctrl.sv
// ----------------------------------------------------------------------------
// lgg_ctrl
// sequencer for cell writes and generation sweeps
// ----------------------------------------------------------------------------
`default_nettype none

module lgg_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire lgg_pkg::ctrl_sts_t sts,
    output lgg_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [1:0] {
        IDLE,
        CELL_WR,
        FILL,
        SWEEP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    if (sts.is_advance)
                    begin
                        cmd.rd_first = 1'b1;
                        state_next   = FILL;
                    end
                    else if (sts.cell_in_range)
                    begin
                        cmd.rd_cell = 1'b1;
                        state_next  = CELL_WR;
                    end
                end
            end
            CELL_WR:
            begin
                cmd.write_cell = 1'b1;
                state_next     = IDLE;
            end
            FILL:
            begin
                cmd.load_window = 1'b1;
                state_next      = SWEEP;
            end
            SWEEP:
            begin
                if (sts.out_free)
                begin
                    cmd.step = 1'b1;
                    if (sts.last_row)
                    begin
                        state_next = IDLE;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/lgg_datapath.sv
// ----------------------------------------------------------------------------
// lgg_datapath
// board memory, three-row window, cell rule and output register
// ----------------------------------------------------------------------------
`default_nettype none

module lgg_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lgg_pkg::in_item_t  in_item,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output lgg_pkg::out_item_t      out_item,
    input  wire lgg_pkg::ctrl_cmd_t cmd,
    output lgg_pkg::ctrl_sts_t      sts
);

    logic [lgg_pkg::COLS-1:0]   board_mem [lgg_pkg::ROWS];
    logic [lgg_pkg::ROWS-1:0]   row_valid_reg;
    logic [lgg_pkg::COLS-1:0]   rd_raw_reg;
    logic                       rd_valid_reg;
    logic [lgg_pkg::COLS-1:0]   rd_data;
    logic [lgg_pkg::COLS-1:0]   prev_reg;
    logic [lgg_pkg::COLS-1:0]   cur_reg;
    logic [lgg_pkg::COLS-1:0]   below;
    logic [lgg_pkg::COLS-1:0]   new_row;
    logic [lgg_pkg::COLS-1:0]   cell_wr_data;
    logic [lgg_pkg::ROW_AW-1:0] cnt_reg;
    logic [lgg_pkg::ROW_AW:0]   cnt_plus2;
    logic [3:0]                 cell_row_reg;
    logic [3:0]                 cell_col_reg;
    logic                       cell_alive_reg;
    logic                       out_valid_reg;
    lgg_pkg::out_item_t         out_item_reg;
    logic                       rd_en;
    logic [lgg_pkg::ROW_AW-1:0] rd_addr;
    logic                       wr_en;
    logic [lgg_pkg::ROW_AW-1:0] wr_addr;
    logic [lgg_pkg::COLS-1:0]   wr_data;
    logic                       last_row;

    // rows never written read as dead
    assign rd_data   = rd_valid_reg ? rd_raw_reg : '0;
    assign last_row  = (cnt_reg == lgg_pkg::LAST_ROW);
    assign cnt_plus2 = {1'b0, cnt_reg} + (lgg_pkg::ROW_AW + 1)'(2);
    assign below     = last_row ? '0 : rd_data;
    assign new_row   = lgg_pkg::life_row(prev_reg, cur_reg, below);

    always_comb
    begin
        for (int j = 0; j < lgg_pkg::COLS; j++)
        begin
            cell_wr_data[j] = (int'(cell_col_reg) == j) ? cell_alive_reg : rd_data[j];
        end
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        priority if (cmd.rd_cell)
        begin
            rd_en   = 1'b1;
            rd_addr = lgg_pkg::ROW_AW'(in_item.row);
        end
        else if (cmd.rd_first)
        begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end
        else if (cmd.load_window)
        begin
            rd_en   = 1'b1;
            rd_addr = lgg_pkg::ROW_AW'(1);
        end
        else if (cmd.step && (cnt_plus2 < lgg_pkg::ROWS_EXT))
        begin
            rd_en   = 1'b1;
            rd_addr = cnt_plus2[lgg_pkg::ROW_AW-1:0];
        end
        else
        begin
            rd_en   = 1'b0;
            rd_addr = '0;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = new_row;
        priority if (cmd.write_cell)
        begin
            wr_en   = 1'b1;
            wr_addr = lgg_pkg::ROW_AW'(cell_row_reg);
            wr_data = cell_wr_data;
        end
        else if (cmd.step)
        begin
            wr_en = 1'b1;
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            board_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= board_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
            if (cmd.step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.rd_first)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.step)
            begin
                cnt_reg <= cnt_reg + lgg_pkg::ROW_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_cell)
        begin
            cell_row_reg   <= in_item.row;
            cell_col_reg   <= in_item.col;
            cell_alive_reg <= in_item.alive;
        end
        if (cmd.load_window)
        begin
            prev_reg <= '0;
            cur_reg  <= rd_data;
        end
        else if (cmd.step)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= rd_data;
        end
        if (cmd.step)
        begin
            out_item_reg.row_index <= 4'(cnt_reg);
            out_item_reg.row_cells <= 16'(new_row);
            out_item_reg.last      <= last_row;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign sts.is_advance    = (in_item.cmd == lgg_pkg::CMD_ADVANCE);
    assign sts.cell_in_range = (int'(in_item.row) < lgg_pkg::ROWS)
                            && (int'(in_item.col) < lgg_pkg::COLS);
    assign sts.out_free      = !out_valid_reg || out_ready;
    assign sts.last_row      = last_row;

endmodule

`default_nettype wire

FILE: hdl/life_grid_generation.sv
// ----------------------------------------------------------------------------
// life_grid_generation
// Conway's Life board (B3/S23, edges dead) with cell load and row output
//
// input channel in_valid/in_ready carries in_item; cmd selects a cell write
// (row, col, alive) or an advance to the next generation. A write outside
// the board is taken and dropped. A cell write gives no output. An advance
// reads row 0 when it is taken, loads it into a three-row window, then
// steps once per board row as the window slides down the board memory,
// writing each new row back in place. Every new row leaves on
// out_valid/out_ready as out_item, row 0 first, last set on the final row.
// The output register lets the last row wait while a new input is taken.
// When the receiver stalls, the sweep holds on the current row and resumes
// when the output register frees. in_ready is high only between commands.
// Reset clears the board to all dead through per-row valid bits, with no
// clearing pass, and drops any pending output.
// ----------------------------------------------------------------------------
`default_nettype none

module life_grid_generation (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire lgg_pkg::in_item_t in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lgg_pkg::out_item_t     out_item
);

    lgg_pkg::ctrl_cmd_t cmd;
    lgg_pkg::ctrl_sts_t sts;

    lgg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lgg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

FILE: hdl/lgg_checker.sv
// ----------------------------------------------------------------------------
// lgg_checker
// port-level checks for the life grid generation block
// ----------------------------------------------------------------------------
`default_nettype none

`include "life_grid_generation_macros.svh"

module lgg_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire lgg_pkg::in_item_t  in_item,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire lgg_pkg::out_item_t out_item
);

    `LGG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))
    `LGG_ASSERT_NEXT(a_adv_busy, in_valid && in_ready && (in_item.cmd == lgg_pkg::CMD_ADVANCE), !in_ready)
    `LGG_ASSERT_NEXT(a_wr_silent, in_valid && in_ready && (in_item.cmd == lgg_pkg::CMD_WRITE), !$rose(out_valid))
    `LGG_ASSERT_NOW(a_last_idx, out_valid && out_item.last, out_item.row_index == 4'(lgg_pkg::ROWS - 1))

endmodule

bind life_grid_generation lgg_checker u_lgg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

`default_nettype wire

FILE: tb/tb_life_grid_generation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_life_grid_generation
// self-checking testbench for the life grid generation block
//
// Drives cell writes and generation advances over the input handshake and
// keeps its own copy of the board. Each advance is turned into the sixteen
// rows it should produce. Every output transfer is compared field by field
// with the oldest of those rows. A short directed table covers the empty
// board, edges and corners, clears and ignored fields. Random writes and
// advances follow in three idling phases, one of which includes a long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------

module tb_life_grid_generation;

    localparam int N_DIRECTED  = 24;
    localparam int N_RANDOM    = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 60;

    typedef struct {
        logic        cmd;
        logic [3:0]  row;
        logic [3:0]  col;
        logic        alive;
        bit          fixed;
        logic [15:0] fixed_cells;
    } step_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    lgg_pkg::in_item_t  in_item;
    logic               out_valid;
    logic               out_ready;
    lgg_pkg::out_item_t out_item;

    logic [lgg_pkg::COLS-1:0] board_model [lgg_pkg::ROWS];
    lgg_pkg::out_item_t       expected_rows [$];
    step_t                    directed_steps [N_DIRECTED];

    int err_count;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_start;
    bit hold_done;
    int hold_cnt;

    life_grid_generation u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (err_count < PRINT_LIMIT)
        begin
            $display("cycle %0d: %s", cycles, what);
        end
        err_count++;
    endtask

    // B3/S23 with dead cells past every edge
    function automatic logic [lgg_pkg::COLS-1:0] next_gen_row(input int r);
        logic [lgg_pkg::COLS-1:0] res;
        int                       n;
        int                       rr;
        int                       cc;
        res = '0;
        for (int c = 0; c < lgg_pkg::COLS; c++)
        begin
            n = 0;
            for (int dr = -1; dr <= 1; dr++)
            begin
                for (int dc = -1; dc <= 1; dc++)
                begin
                    rr = r + dr;
                    cc = c + dc;
                    if ((dr != 0 || dc != 0) && rr >= 0 && rr < lgg_pkg::ROWS
                        && cc >= 0 && cc < lgg_pkg::COLS)
                    begin
                        n += int'(board_model[rr][cc]);
                    end
                end
            end
            res[c] = (n == 3) || (board_model[r][c] && n == 2);
        end
        return res;
    endfunction

    task automatic apply_command(input lgg_pkg::in_item_t it, input bit fixed,
                                 input logic [15:0] fixed_cells);
        logic [lgg_pkg::COLS-1:0] next_board [lgg_pkg::ROWS];
        lgg_pkg::out_item_t       e;
        if (it.cmd == lgg_pkg::CMD_WRITE)
        begin
            if (int'(it.row) < lgg_pkg::ROWS && int'(it.col) < lgg_pkg::COLS)
            begin
                board_model[it.row][it.col] = it.alive;
            end
        end
        else
        begin
            for (int r = 0; r < lgg_pkg::ROWS; r++)
            begin
                next_board[r] = next_gen_row(r);
            end
            for (int r = 0; r < lgg_pkg::ROWS; r++)
            begin
                board_model[r] = next_board[r];
                e.row_index = 4'(r);
                e.row_cells = fixed ? fixed_cells : 16'(next_board[r]);
                e.last      = (r == lgg_pkg::ROWS - 1);
                expected_rows.push_back(e);
            end
        end
    endtask

    // valid stays up between back-to-back transfers
    task automatic send_item(input lgg_pkg::in_item_t it, input bit fixed,
                             input logic [15:0] fixed_cells);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        apply_command(it, fixed, fixed_cells);
    endtask

    always @(posedge clk)
    begin
        if (hold_start && !hold_done)
        begin
            hold_done = 1'b1;
            hold_cnt  = HOLD_CYCLES;
        end
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        lgg_pkg::out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rows.size() == 0)
            begin
                report_mismatch($sformatf("unexpected row %0d", out_item.row_index));
            end
            else
            begin
                e = expected_rows.pop_front();
                if (out_item.row_index !== e.row_index)
                begin
                    report_mismatch($sformatf("row_index %0d, expected %0d",
                                              out_item.row_index, e.row_index));
                end
                if (out_item.row_cells !== e.row_cells)
                begin
                    report_mismatch($sformatf("row %0d cells %h, expected %h",
                                              e.row_index, out_item.row_cells, e.row_cells));
                end
                if (out_item.last !== e.last)
                begin
                    report_mismatch($sformatf("row %0d last %b, expected %b",
                                              e.row_index, out_item.last, e.last));
                end
            end
        end
    end

    initial
    begin
        lgg_pkg::in_item_t it;
        int                per_phase;
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        hold_start    = 1'b0;
        send_idle_pct = 29;
        recv_idle_pct = 69;
        for (int r = 0; r < lgg_pkg::ROWS; r++)
        begin
            board_model[r] = '0;
        end

        directed_steps = '{
            '{lgg_pkg::CMD_ADVANCE, 4'd0,  4'd0,  1'b0, 1'b1, 16'h0000},  // empty board
            '{lgg_pkg::CMD_WRITE,   4'd0,  4'd0,  1'b1, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_WRITE,   4'd0,  4'd15, 1'b1, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_WRITE,   4'd15, 4'd0,  1'b1, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_WRITE,   4'd15, 4'd15, 1'b1, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_ADVANCE, 4'd0,  4'd0,  1'b0, 1'b1, 16'h0000},  // lone corners die
            '{lgg_pkg::CMD_WRITE,   4'd0,  4'd6,  1'b1, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_WRITE,   4'd0,  4'd7,  1'b1, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_WRITE,   4'd0,  4'd8,  1'b1, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_ADVANCE, 4'd0,  4'd0,  1'b0, 1'b0, 16'h0000},  // blinker on top
            '{lgg_pkg::CMD_WRITE,   4'd14, 4'd14, 1'b1, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_WRITE,   4'd14, 4'd15, 1'b1, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_WRITE,   4'd15, 4'd14, 1'b1, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_WRITE,   4'd15, 4'd15, 1'b1, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_WRITE,   4'd15, 4'd15, 1'b0, 1'b0, 16'h0000},  // clear a cell
            '{lgg_pkg::CMD_WRITE,   4'd15, 4'd15, 1'b1, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_ADVANCE, 4'd15, 4'd15, 1'b1, 1'b0, 16'h0000},  // unused fields set
            '{lgg_pkg::CMD_ADVANCE, 4'd0,  4'd0,  1'b0, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_WRITE,   4'd7,  4'd0,  1'b1, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_WRITE,   4'd8,  4'd0,  1'b1, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_WRITE,   4'd9,  4'd0,  1'b1, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_ADVANCE, 4'd9,  4'd6,  1'b1, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_WRITE,   4'd0,  4'd7,  1'b0, 1'b0, 16'h0000},
            '{lgg_pkg::CMD_ADVANCE, 4'd0,  4'd0,  1'b0, 1'b0, 16'h0000}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
        begin
            it.cmd   = directed_steps[i].cmd;
            it.row   = directed_steps[i].row;
            it.col   = directed_steps[i].col;
            it.alive = directed_steps[i].alive;
            send_item(it, directed_steps[i].fixed, directed_steps[i].fixed_cells);
        end

        per_phase = N_RANDOM / 3;
        for (int phase = 0; phase < 3; phase++)
        begin
            unique case (phase)
                0:
                begin
                    send_idle_pct = 29;
                    recv_idle_pct = 69;
                end
                1:
                begin
                    send_idle_pct = 69;
                    recv_idle_pct = 29;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_start    = 1'b1;
                end
            endcase
            for (int n = 0; n < per_phase + (phase == 2 ? N_RANDOM % 3 : 0); n++)
            begin
                // mostly cell writes that build up a live region, some advances
                it.cmd   = ($urandom_range(9) == 0) ? lgg_pkg::CMD_ADVANCE : lgg_pkg::CMD_WRITE;
                it.row   = 4'($urandom_range(15));
                it.col   = 4'($urandom_range(15));
                it.alive = ($urandom_range(99) < 60);
                send_item(it, 1'b0, 16'h0000);
            end
        end
        in_valid <= 1'b0;

        while (expected_rows.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
